// ----- hw/rtl/wsfu_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types and constants for the WebSocket frame unmasker.
// ----------------------------------------------------------------------------
package wsfu_pkg;

	// default width of the frame length counter
	localparam int LENGTH_BITS_DEF = 64;

	// 7-bit length field codes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// header byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	// result of one parse step, parser to top
	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       last_byte;
		logic       empty_frame;
	} wsfu_res_t;

endpackage

// ----- hw/rtl/wsfu_in_if.sv -----
// ----------------------------------------------------------------------------
// wsfu_in_if
// Received byte channel: one frame stream byte per beat.
// ----------------------------------------------------------------------------
interface wsfu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_begin;

	modport source (output valid, output rx_byte, output frame_begin, input ready);
	modport sink   (input valid, input rx_byte, input frame_begin, output ready);
endinterface

// ----- hw/rtl/wsfu_out_if.sv -----
// ----------------------------------------------------------------------------
// wsfu_out_if
// Unmasked payload channel: one payload byte or empty marker per beat.
// ----------------------------------------------------------------------------
interface wsfu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;
	logic       empty_frame;

	modport source (output valid, output payload_byte, output last_byte,
		output empty_frame, input ready);
	modport sink   (input valid, input payload_byte, input last_byte,
		input empty_frame, output ready);
endinterface

// ----- hw/rtl/wsfu_parser.sv -----
// ----------------------------------------------------------------------------
// wsfu_parser
// Frame header parser and payload unmasker. Holds the parse state, updates it
// on each step and presents the result of the current byte combinationally.
// ----------------------------------------------------------------------------
module wsfu_parser #(
	parameter int LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic                frame_begin,
	output wsfu_pkg::wsfu_res_t res
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_MASK = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [3:0]             hdr_cnt_q, hdr_cnt_d;
	logic [3:0]             hdr_cnt_nx;
	logic [3:0]             ext_need;
	logic                   ext64_q, ext64_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             pos_q, pos_d;
	logic [7:0]             key_byte;
	logic [6:0]             len7;
	logic                   data_last;

	assign len7       = rx_byte[6:0];
	assign hdr_cnt_nx = hdr_cnt_q + 4'd1;
	assign ext_need   = ext64_q ? wsfu_pkg::EXT64_BYTES : wsfu_pkg::EXT16_BYTES;
	assign data_last  = (len_q == LENGTH_BITS'(1));

	// mask key byte for the current payload position, first key byte on top
	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result of this byte
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		ext64_d   = ext64_q;
		len_d     = len_q;
		key_d     = key_q;
		pos_d     = pos_q;
		res       = '0;
		if (frame_begin) begin
			// new frame drops whatever was in progress
			phase_d   = PH_LEN;
			hdr_cnt_d = 4'd0;
			len_d     = '0;
			pos_d     = 2'd0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_LEN: begin
					hdr_cnt_d = 4'd0;
					if (len7 == wsfu_pkg::LEN_EXT16) begin
						ext64_d = 1'b0;
						len_d   = '0;
						phase_d = PH_EXT;
					end else if (len7 == wsfu_pkg::LEN_EXT64) begin
						ext64_d = 1'b1;
						len_d   = '0;
						phase_d = PH_EXT;
					end else begin
						len_d   = LENGTH_BITS'(len7);
						phase_d = PH_MASK;
					end
				end
				PH_EXT: begin
					// big-endian shift, upper bits fall off
					len_d = {len_q[LENGTH_BITS-9:0], rx_byte};
					if (hdr_cnt_nx >= ext_need) begin
						hdr_cnt_d = 4'd0;
						phase_d   = PH_MASK;
					end else begin
						hdr_cnt_d = hdr_cnt_nx;
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					if (hdr_cnt_nx >= wsfu_pkg::MASK_BYTES) begin
						hdr_cnt_d = 4'd0;
						pos_d     = 2'd0;
						if (len_q == '0) begin
							// zero-length frame: one empty marker
							phase_d         = PH_IDLE;
							res.valid       = 1'b1;
							res.last_byte   = 1'b1;
							res.empty_frame = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end else begin
						hdr_cnt_d = hdr_cnt_nx;
					end
				end
				PH_DATA: begin
					res.valid        = 1'b1;
					res.payload_byte = rx_byte ^ key_byte;
					res.last_byte    = data_last;
					len_d            = len_q - LENGTH_BITS'(1);
					pos_d            = pos_q + 2'd1;
					if (data_last) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hdr_cnt_q <= 4'd0;
			ext64_q   <= 1'b0;
			len_q     <= '0;
			key_q     <= '0;
			pos_q     <= 2'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			ext64_q   <= ext64_d;
			len_q     <= len_d;
			key_q     <= key_d;
			pos_q     <= pos_d;
		end
	end

	// payload phase always has bytes left to count
	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (len_q != '0))
		else $error("payload phase with zero remaining length");

	// header counter stays within the longest header field
	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q < wsfu_pkg::EXT64_BYTES)
		else $error("header byte counter out of range");

endmodule

// ----- hw/rtl/websocket_frame_unmasker.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses WebSocket client frames byte by byte and emits unmasked payload.
// ----------------------------------------------------------------------------
// Pipeline: a byte is captured in the input register and its result, if any, is
//   then registered in the output register (two register stages, accept to result).
// Throughput: one byte per cycle while the output is not stalled, set by the single
//   parse step per byte (length counter decrement and compare) between the two registers.
// Reset: asynchronous; parser idle waiting for a frame start, no beats held.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker #(
	parameter int LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	wsfu_in_if.sink           rx,
	wsfu_out_if.source        tx
);

	logic                vld_s1;
	logic [7:0]          rx_byte_s1;
	logic                frame_begin_s1;
	logic                s1_fire;
	logic                out_free;
	logic                rx_accept;
	wsfu_pkg::wsfu_res_t res;
	logic                tx_vld_q;
	logic [7:0]          payload_byte_q;
	logic                last_byte_q;
	logic                empty_frame_q;

	// handshake: stage 1 moves on when its result has room or it has none
	assign out_free  = !tx_vld_q || tx.ready;
	assign s1_fire   = vld_s1 && (!res.valid || out_free);
	assign rx.ready  = !vld_s1 || s1_fire;
	assign rx_accept = rx.valid && rx.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx_accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_accept) begin
			rx_byte_s1     <= rx.rx_byte;
			frame_begin_s1 <= rx.frame_begin;
		end
	end

	wsfu_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_fire),
		.rx_byte     (rx_byte_s1),
		.frame_begin (frame_begin_s1),
		.res         (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_vld_q <= 1'b0;
		end else if (s1_fire && res.valid) begin
			tx_vld_q <= 1'b1;
		end else if (tx.ready) begin
			tx_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.valid) begin
			payload_byte_q <= res.payload_byte;
			last_byte_q    <= res.last_byte;
			empty_frame_q  <= res.empty_frame;
		end
	end

	assign tx.valid        = tx_vld_q;
	assign tx.payload_byte = payload_byte_q;
	assign tx.last_byte    = last_byte_q;
	assign tx.empty_frame  = empty_frame_q;

	// empty marker carries last and a zero byte
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_vld_q && empty_frame_q) |-> (last_byte_q && (payload_byte_q == 8'd0)))
		else $error("malformed empty frame marker");

	// input is only held off by a stalled stage 1
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (vld_s1 && res.valid && tx_vld_q && !tx.ready))
		else $error("input stalled without a blocked result");

	// a blocked stage 1 keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_fire) |=> (vld_s1 && $stable(rx_byte_s1)
			&& $stable(frame_begin_s1)))
		else $error("stage 1 byte lost while stalled");

	// a pending result is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_vld_q && !tx.ready) |-> !(s1_fire && res.valid))
		else $error("output register overwritten while pending");

endmodule

// ----- tb/websocket_frame_unmasker_tb.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_tb
// Feeds client frame byte streams (complete, cut short, and stray bytes)
// through the unmasker under several handshake idle mixes. A cycle-free
// parser model predicts every payload byte and empty marker. Results are
// compared in order against that model.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_W = wsfu_pkg::LENGTH_BITS_DEF;
	localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_W);
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {PH_IDLE, PH_LEN, PH_EXT, PH_MASK, PH_DATA} parse_phase_e;
	typedef enum int {FR_LEN7, FR_EXT16, FR_EXT64} frame_kind_e;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} rx_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_empty;
	} unmasked_t;

	logic clk;
	logic arst_n;

	wsfu_in_if  rx();
	wsfu_out_if tx();

	websocket_frame_unmasker #(.LENGTH_BITS(LEN_W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	// stimulus and expectations
	rx_beat_t  byte_q[$];
	unmasked_t payload_q[$];
	int        queued = 0;
	int        errors = 0;
	int        idle_cycles = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        taken_cnt = 0;
	int        seen_cnt = 0;
	int        hold_reqs = 0;
	int        holds_started = 0;
	int        hold_left = 0;

	// parser model state
	parse_phase_e phase = PH_IDLE;
	logic [3:0]   hdr_cnt = '0;
	logic [3:0]   ext_need = '0;
	logic [63:0]  frame_len = '0;
	logic [63:0]  bytes_left = '0;
	logic [31:0]  key = '0;
	logic [1:0]   key_pos = '0;

	// directed beats: {start, byte}
	localparam logic [8:0] DIRECTED[25] = '{
		// zero-length frame, mask bit set
		9'h181, 9'h080, 9'h000, 9'h000, 9'h000, 9'h000,
		// stray byte while idle
		9'h0FF,
		// one-byte frame, mask bit clear, all-ones key
		9'h100, 9'h001, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000,
		// new frame start inside the header
		9'h182, 9'h0FE,
		// 16-bit extended length of one, below 126
		9'h182, 9'h0FE, 9'h000, 9'h001, 9'h012, 9'h034, 9'h056, 9'h078, 9'h0FF
	};

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// one parse step per accepted byte
	task automatic unmask_step(input logic [7:0] b, input logic start);
		unmasked_t r;
		if (start) begin
			phase = PH_LEN;
			hdr_cnt = '0;
			frame_len = '0;
			bytes_left = '0;
			key_pos = '0;
		end else begin
			case (phase)
			PH_LEN: begin
				hdr_cnt = '0;
				if (b[6:0] == wsfu_pkg::LEN_EXT16) begin
					ext_need = wsfu_pkg::EXT16_BYTES;
					frame_len = '0;
					phase = PH_EXT;
				end else if (b[6:0] == wsfu_pkg::LEN_EXT64) begin
					ext_need = wsfu_pkg::EXT64_BYTES;
					frame_len = '0;
					phase = PH_EXT;
				end else begin
					frame_len = {57'd0, b[6:0]} & LEN_MASK;
					phase = PH_MASK;
				end
			end
			PH_EXT: begin
				frame_len = ((frame_len << 8) | {56'd0, b}) & LEN_MASK;
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= ext_need) begin
					hdr_cnt = '0;
					phase = PH_MASK;
				end
			end
			PH_MASK: begin
				key = {key[23:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= wsfu_pkg::MASK_BYTES) begin
					hdr_cnt = '0;
					key_pos = '0;
					if (frame_len == '0) begin
						// empty marker
						r = '{data: 8'h00, last: 1'b1, is_empty: 1'b1};
						payload_q.push_back(r);
						phase = PH_IDLE;
					end else begin
						bytes_left = frame_len;
						phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				r.data = b ^ key[8 * (3 - key_pos) +: 8];
				key_pos = key_pos + 2'd1;
				bytes_left = bytes_left - 64'd1;
				r.last = (bytes_left == '0);
				r.is_empty = 1'b0;
				payload_q.push_back(r);
				if (r.last)
					phase = PH_IDLE;
			end
			default: phase = PH_IDLE;
			endcase
		end
	endtask

	task automatic push_beat(input logic [7:0] b, input logic start);
		byte_q.push_back('{data: b, start: start});
	endtask

	// one frame, optionally cut short after keep bytes
	task automatic push_frame(input frame_kind_e kind, input logic [63:0] len, input int keep);
		logic [7:0] fr[$];
		logic       mask_bit;
		int         n_body;
		int         n;
		mask_bit = ($urandom_range(1) == 1);
		fr.push_back(8'($urandom_range(255)));
		case (kind)
		FR_LEN7: begin
			fr.push_back({mask_bit, len[6:0]});
		end
		FR_EXT16: begin
			fr.push_back({mask_bit, wsfu_pkg::LEN_EXT16});
			fr.push_back(len[15:8]);
			fr.push_back(len[7:0]);
		end
		default: begin
			fr.push_back({mask_bit, wsfu_pkg::LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				fr.push_back(len[8 * i +: 8]);
		end
		endcase
		repeat (4) fr.push_back(8'($urandom_range(255)));
		n_body = (len > 64'd400) ? 400 : int'(len);
		repeat (n_body) fr.push_back(8'($urandom_range(255)));
		n = (keep < 0 || keep > fr.size()) ? fr.size() : keep;
		for (int i = 0; i < n; i++)
			push_beat(fr[i], i == 0);
		queued += n;
	endtask

	// mostly short payloads, some empty, a few past the 7-bit range
	function automatic logic [63:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 64'd0;
		else if (r < 80)
			return 64'($urandom_range(1, 12));
		else if (r < 95)
			return 64'($urandom_range(13, 125));
		return 64'($urandom_range(126, 300));
	endfunction

	task automatic add_random(input int quota);
		int          base;
		int          r;
		int          kr;
		frame_kind_e kind;
		logic [63:0] len;
		base = queued;
		while (queued - base < quota) begin
			r = $urandom_range(99);
			kr = $urandom_range(9);
			kind = (kr < 6) ? FR_LEN7 : (kr < 9) ? FR_EXT16 : FR_EXT64;
			len = pick_len();
			if (kind == FR_LEN7 && len > 64'd125)
				len = 64'd125;
			if (r < 70) begin
				push_frame(kind, len, -1);
			end else if (r < 82) begin
				// broken off anywhere in header or payload
				push_frame(kind, len, $urandom_range(1, 14 + int'(len)));
			end else if (r < 90) begin
				// huge 64-bit length, top bit either way, cut by the next start
				len = {$urandom, $urandom};
				push_frame(FR_EXT64, len, $urandom_range(10, 40));
			end else begin
				// line noise
				repeat ($urandom_range(1, 3))
					push_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
	endtask

	task automatic run_phase(input int src_pct, input int sink_pct, input int quota,
		input bit hold);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		add_random(quota);
		if (hold)
			hold_reqs++;
		while (byte_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void report(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.rx_byte <= '0;
			rx.frame_begin <= 1'b0;
		end else if (!rx.valid || taken_cnt != seen_cnt) begin
			seen_cnt = taken_cnt;
			if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				rx.valid <= 1'b1;
				rx.rx_byte <= byte_q[0].data;
				rx.frame_begin <= byte_q[0].start;
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// accepted bytes go through the model
	always @(posedge clk) begin
		if (arst_n && rx.valid && rx.ready) begin
			unmask_step(rx.rx_byte, rx.frame_begin);
			void'(byte_q.pop_front());
			taken_cnt++;
		end
	end

	// payload sink, with an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			tx.ready <= 1'b0;
		end else if (hold_left > 0) begin
			tx.ready <= 1'b0;
			hold_left--;
		end else if (hold_reqs != holds_started) begin
			holds_started = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			tx.ready <= 1'b0;
		end else begin
			tx.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		unmasked_t exp;
		if (arst_n && tx.valid && tx.ready) begin
			if (payload_q.size() == 0) begin
				report($sformatf("unexpected beat: byte %02h last %0b empty %0b",
					tx.payload_byte, tx.last_byte, tx.empty_frame));
			end else begin
				exp = payload_q.pop_front();
				if (tx.payload_byte !== exp.data || tx.last_byte !== exp.last ||
					tx.empty_frame !== exp.is_empty)
					report($sformatf({"mismatch: exp byte %02h last %0b empty %0b, ",
						"got byte %02h last %0b empty %0b"},
						exp.data, exp.last, exp.is_empty,
						tx.payload_byte, tx.last_byte, tx.empty_frame));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx.valid && rx.ready) || (tx.valid && tx.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// sequence
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		#2 arst_n = 1'b1;

		foreach (DIRECTED[i])
			push_beat(DIRECTED[i][7:0], DIRECTED[i][8]);

		// no idling, with one long sink hold-off to back up the input
		run_phase(0, 0, 200, 1'b1);
		run_phase(59, 0, 200, 1'b0);
		run_phase(0, 59, 200, 1'b0);
		run_phase(17, 17, 200, 1'b0);

		while (byte_q.size() != 0 || payload_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
